// ===== sv/dcb_pkg.sv =====
// Shared types and constants of the DC blocker with non-finite sample repair.
package dcb_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam int LEVEL_W     = $clog2(QUEUE_DEPTH) + 1;
	localparam int CFG_INDEX_W = 2;

	// register indexes on the write port
	localparam logic [CFG_INDEX_W-1:0] REG_BLOCKER_POLE = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_BLOCKER_GAIN = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_METER_POLE   = 2'd2;

	localparam logic [23:0] BLOCKER_POLE_RST = 24'd16770629;
	localparam logic [23:0] BLOCKER_GAIN_RST = 24'd16773922;
	localparam logic [23:0] METER_POLE_RST   = 24'd16776996;

	localparam logic [7:0] EXP_SPECIAL = 8'hFF;
	localparam logic [7:0] EXP_BIAS    = 8'd127;

	typedef struct packed {
		logic [23:0] blocker_pole;
		logic [23:0] blocker_gain;
		logic [23:0] meter_pole;
	} coef_t;

	// classified item between front and back
	typedef struct packed {
		logic               repaired;
		logic signed [23:0] x;
		logic [2:0]         channel;
		logic [2:0]         ch_mod;
		logic               clear;
	} mid_item_t;

	typedef struct packed {
		logic signed [23:0] sample_out;
		logic [2:0]         channel_out;
		logic               was_repaired;
		logic [23:0]        offset_peak;
		logic [31:0]        repair_count;
	} res_item_t;

endpackage

// ===== sv/dcb_fifo.sv =====
// Small register queue used between the block's parts.
module dcb_fifo import dcb_pkg::*; #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr,
	input  logic [WIDTH-1:0]           wdata,
	output logic                       full,
	input  logic                       rd,
	output logic [WIDTH-1:0]           rdata,
	output logic                       empty,
	output logic [$clog2(DEPTH):0]     level
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0]      mem_q [DEPTH];
	logic [AW-1:0]         wptr_q;
	logic [AW-1:0]         rptr_q;
	logic [$clog2(DEPTH):0] count_q;
	logic                  do_wr;
	logic                  do_rd;

	assign full  = (count_q == ($clog2(DEPTH)+1)'(DEPTH));
	assign empty = (count_q == '0);
	assign level = count_q;
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/dcb_front.sv =====
// Front part: flags non-finite samples, converts float to Q1.23, folds the channel.
module dcb_front import dcb_pkg::*; #(
	parameter int CHANNELS = 8
) (
	input  logic [31:0] sample_bits,
	input  logic [2:0]  channel,
	input  logic        clear_meters,
	output mid_item_t   item
);

	always_comb begin
		logic [7:0]  expo;
		logic [23:0] mant;
		logic [7:0]  sh;
		logic [24:0] rnd;
		logic [24:0] q;
		logic [2:0]  v;
		expo = sample_bits[30:23];
		mant = {1'b1, sample_bits[22:0]};
		sh   = EXP_BIAS - expo;
		rnd  = '0;
		if (expo == '0) begin
			q = '0;
		end else if (expo >= EXP_BIAS) begin
			q = 25'd8388608;
		end else if (sh >= 8'd25) begin
			q = '0;
		end else begin
			rnd = {1'b0, mant} + (25'd1 << (sh - 8'd1));
			q   = rnd >> sh;
		end

		if (sample_bits[31]) begin
			item.x = $signed(24'(25'd0 - q));
		end else if (q > 25'd8388607) begin
			item.x = 24'sh7FFFFF;
		end else begin
			item.x = $signed(q[23:0]);
		end

		// channel modulo CHANNELS by repeated subtraction (narrow)
		v = channel;
		for (int i = 0; i < 7; i++) begin
			if (int'(v) >= CHANNELS) begin
				v = v - 3'(CHANNELS);
			end
		end

		item.repaired = (expo == EXP_SPECIAL);
		item.channel  = channel;
		item.ch_mod   = v;
		item.clear    = clear_meters;
	end

endmodule

// ===== sv/dcb_back.sv =====
// Back part: per-channel DC blocker, baseline meter, peak hold and repair count.
module dcb_back import dcb_pkg::*; #(
	parameter int CHANNELS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  mid_item_t          head,
	input  logic               head_valid,
	output logic               head_pop,
	input  coef_t              coef,
	input  logic [LEVEL_W-1:0] out_level,
	output logic               res_push,
	output res_item_t          res
);

	localparam int CHW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
		if ((v[34:31] == 4'b0000) || (v[34:31] == 4'b1111)) begin
			return v[31:0];
		end
		return {v[34], {31{~v[34]}}};
	endfunction

	// per-channel history
	logic signed [23:0] prev_input_q  [CHANNELS];
	logic signed [31:0] prev_output_q [CHANNELS];
	logic signed [31:0] baseline_q    [CHANNELS];
	logic [23:0]        peak_q;
	logic [31:0]        repairs_q;

	logic [CHW-1:0]     head_ci;
	logic               hazard;
	logic               room;

	logic signed [49:0] prod_g;
	logic signed [56:0] prod_p;
	logic signed [57:0] prod_m;

	logic               valid_s1;
	logic               repaired_s1;
	logic               clear_s1;
	logic [2:0]         channel_s1;
	logic [CHW-1:0]     ci_s1;
	logic signed [23:0] x_s1;
	logic signed [49:0] prod_g_s1;
	logic signed [56:0] prod_p_s1;
	logic signed [57:0] prod_m_s1;

	logic signed [31:0] y_new;
	logic signed [31:0] est_new;
	logic signed [23:0] y_q23;
	logic [23:0]        mag23;
	logic [23:0]        peak_new;
	logic [31:0]        repairs_new;

	assign head_ci  = CHW'(head.ch_mod);
	// the state of a channel still in stage 1 is written at this edge
	assign hazard   = valid_s1 && (ci_s1 == head_ci);
	assign room     = (out_level + LEVEL_W'(valid_s1)) < LEVEL_W'(QUEUE_DEPTH);
	assign head_pop = head_valid && room && !hazard;

	// issue: read history, form the three products
	always_comb begin
		logic signed [24:0] dx;
		logic signed [31:0] x31;
		logic signed [32:0] diff;
		dx     = $signed({head.x[23], head.x}) -
		         $signed({prev_input_q[head_ci][23], prev_input_q[head_ci]});
		x31    = {head.x, 8'b0};
		diff   = $signed({baseline_q[head_ci][31], baseline_q[head_ci]}) -
		         $signed({x31[31], x31});
		prod_g = dx * $signed({1'b0, coef.blocker_gain});
		prod_p = prev_output_q[head_ci] * $signed({1'b0, coef.blocker_pole});
		prod_m = diff * $signed({1'b0, coef.meter_pole});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= head_pop;
		end
	end

	always_ff @(posedge clk) begin
		if (head_pop) begin
			repaired_s1 <= head.repaired;
			clear_s1    <= head.clear;
			channel_s1  <= head.channel;
			ci_s1       <= head_ci;
			x_s1        <= head.x;
			prod_g_s1   <= prod_g;
			prod_p_s1   <= prod_p;
			prod_m_s1   <= prod_m;
		end
	end

	// stage 1: sum, round, saturate, meters
	always_comb begin
		logic signed [58:0] acc;
		logic signed [32:0] yt;
		logic signed [24:0] yq;
		logic signed [57:0] pm;
		logic signed [33:0] rnd;
		logic signed [34:0] est;
		logic signed [31:0] x31;
		logic [32:0]        mag;
		logic [32:0]        msum;
		acc   = $signed({prod_g_s1[49], prod_g_s1, 8'b0}) +
		        $signed({{2{prod_p_s1[56]}}, prod_p_s1}) + 59'sd8388608;
		y_new = sat32(acc[58:24]);
		yt    = $signed({y_new[31], y_new}) + 33'sd128;
		yq    = yt[32:8];
		y_q23 = (yq[24] == yq[23]) ? yq[23:0] : {yq[24], {23{~yq[24]}}};

		x31     = {x_s1, 8'b0};
		pm      = prod_m_s1 + 58'sd8388608;
		rnd     = pm[57:24];
		est     = $signed({{3{x31[31]}}, x31}) + $signed({rnd[33], rnd});
		est_new = sat32(est);
		mag     = est_new[31] ? (33'd0 - {est_new[31], est_new}) : {1'b0, est_new};
		msum    = mag + 33'd128;
		mag23   = msum[31:8];

		peak_new    = peak_q;
		repairs_new = repairs_q;
		if (repaired_s1) begin
			if (repairs_q != '1) begin
				repairs_new = repairs_q + 32'd1;
			end
		end else if (mag23 > peak_q) begin
			peak_new = mag23;
		end
	end

	assign res_push         = valid_s1;
	assign res.sample_out   = repaired_s1 ? 24'sd0 : y_q23;
	assign res.channel_out  = channel_s1;
	assign res.was_repaired = repaired_s1;
	assign res.offset_peak  = peak_new;
	assign res.repair_count = repairs_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				prev_input_q[i]  <= '0;
				prev_output_q[i] <= '0;
				baseline_q[i]    <= '0;
			end
			peak_q    <= '0;
			repairs_q <= '0;
		end else if (valid_s1) begin
			if (repaired_s1) begin
				prev_input_q[ci_s1]  <= '0;
				prev_output_q[ci_s1] <= '0;
				baseline_q[ci_s1]    <= '0;
			end else begin
				prev_input_q[ci_s1]  <= x_s1;
				prev_output_q[ci_s1] <= y_new;
				baseline_q[ci_s1]    <= est_new;
			end
			peak_q    <= clear_s1 ? '0 : peak_new;
			repairs_q <= clear_s1 ? '0 : repairs_new;
		end
	end

endmodule

// ===== sv/dc_blocker_with_nan_repair.sv =====
// An item goes from the input queue through the stage 1 registers to the result queue.
// Throughput: one item per cycle while the result queue has room; an item for the
//   same channel as the one just issued waits until stage 1 has written its history.
// Input and result queues hold QUEUE_DEPTH items each; full and empty gate the sides.
// Reset (arst_n low, asynchronous): queues empty, all channel histories, the peak hold
//   and the repair count zero, coefficients back to their default values.
module dc_blocker_with_nan_repair import dcb_pkg::*; #(
	parameter int CHANNELS = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// item input queue
	input  logic                   push,
	output logic                   full,
	input  logic [31:0]            sample_bits,
	input  logic [2:0]             channel,
	input  logic                   clear_meters,
	// result queue
	output logic                   empty,
	input  logic                   pop,
	output logic signed [23:0]     sample_out,
	output logic [2:0]             channel_out,
	output logic                   was_repaired,
	output logic [23:0]            offset_peak,
	output logic [31:0]            repair_count,
	// coefficient writes
	input  logic                   wr_en,
	input  logic [CFG_INDEX_W-1:0] wr_index,
	input  logic [23:0]            wr_data
);

	coef_t              coef_q;
	mid_item_t          front_item;
	mid_item_t          head_item;
	logic               mid_empty;
	logic               head_pop;
	logic [LEVEL_W-1:0] mid_level;
	logic               res_push;
	res_item_t          res_in;
	res_item_t          res_out;
	logic               res_full;
	logic [LEVEL_W-1:0] res_level;

	// Coefficient registers; an index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.blocker_pole <= BLOCKER_POLE_RST;
			coef_q.blocker_gain <= BLOCKER_GAIN_RST;
			coef_q.meter_pole   <= METER_POLE_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_BLOCKER_POLE: coef_q.blocker_pole <= wr_data;
				REG_BLOCKER_GAIN: coef_q.blocker_gain <= wr_data;
				REG_METER_POLE:   coef_q.meter_pole   <= wr_data;
				default: ;
			endcase
		end
	end

	// Front: classify each item as it is taken in.
	dcb_front #(.CHANNELS(CHANNELS)) u_front (
		.sample_bits  (sample_bits),
		.channel      (channel),
		.clear_meters (clear_meters),
		.item         (front_item)
	);

	// Queue between front and back; its full flag is the input's full.
	dcb_fifo #(.WIDTH($bits(mid_item_t)), .DEPTH(QUEUE_DEPTH)) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (push),
		.wdata  (front_item),
		.full   (full),
		.rd     (head_pop),
		.rdata  (head_item),
		.empty  (mid_empty),
		.level  (mid_level)
	);

	// Back: two-stage filter; issues only with room reserved in the result queue.
	dcb_back #(.CHANNELS(CHANNELS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head_item),
		.head_valid (!mid_empty && (mid_level != '0)),
		.head_pop   (head_pop),
		.coef       (coef_q),
		.out_level  (res_level),
		.res_push   (res_push),
		.res        (res_in)
	);

	// Result queue: parts the back from the consumer.
	dcb_fifo #(.WIDTH($bits(res_item_t)), .DEPTH(QUEUE_DEPTH)) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.rd     (pop),
		.rdata  (res_out),
		.empty  (empty),
		.level  (res_level)
	);

	// res_full never blocks a push: the back reserves a slot before issuing
	assign sample_out   = res_full ? res_out.sample_out : res_out.sample_out;
	assign channel_out  = res_out.channel_out;
	assign was_repaired = res_out.was_repaired;
	assign offset_peak  = res_out.offset_peak;
	assign repair_count = res_out.repair_count;

endmodule
